[sv/bds_pkg.sv]
// Shared types and constants of the 2x2 box downsampler.
// No dependencies; every other file but bds_ram refers to it by scoped names.
package bds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 8;
  localparam int PAIR_W     = PIX_W + 1;
  localparam int SUM_W      = PIX_W + 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic              read;
    logic [SLOT_W-1:0] slot;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } op_t;

endpackage

[sv/bds_if.sv]
// Stream channels of the downsampler: raw pixels in, averaged pixels out.
// Depends on bds_pkg for field widths.
interface bds_in_if;
  logic                        valid;
  logic                        ready;
  logic [bds_pkg::PIX_W-1:0]   pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface bds_out_if;
  logic                        valid;
  logic                        ready;
  logic [bds_pkg::PIX_W-1:0]   pixel_out;
  logic                        frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

[sv/box_downsample_2x2_unit.sv]
// Top level of the 2x2 box downsampler: APB registers, front, queue, back.
// Depends on bds_pkg, bds_if, bds_front, bds_queue, bds_back.
//
//   channel  dir  payload                 handshake
//   raw      in   pixel_in[7:0]           valid/ready
//   avg      out  pixel_out[7:0], last    valid/ready
//   apb      in   width @0, height @4     psel/penable/pwrite
//
// One pixel per cycle while the queue has room; the back end retires one queued operation a cycle
// unless a read waits on an output stall. A block's odd-row pair goes via queue, s1, output register.
// Reset clears counters, queue and valids; the line store is not cleared.
// An output stall fills the queue, then drops raw.ready.
module box_downsample_2x2_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bds_pkg::ADDR_W-1:0]  paddr,
  input  logic [bds_pkg::DATA_W-1:0]  pwdata,
  output logic [bds_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  bds_in_if.sink                      raw,
  bds_out_if.source                   avg
);

  logic [bds_pkg::SIZE_W-1:0] src_w, src_h;
  logic                       wr;
  logic                       push, q_full, head_valid, pop;
  bds_pkg::op_t               push_op, head_op;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= bds_pkg::RESET_WIDTH;
      src_h <= bds_pkg::RESET_HEIGHT;
    end else if (wr) begin
      if (paddr[2] == bds_pkg::REG_WIDTH) begin
        src_w <= pwdata[bds_pkg::SIZE_W-1:0];
      end else begin
        src_h <= pwdata[bds_pkg::SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == bds_pkg::REG_HEIGHT) ? bds_pkg::DATA_W'(src_h)
                                                    : bds_pkg::DATA_W'(src_w);

  bds_front u_front (
    .clk     (clk),
    .rst     (rst),
    .src_w   (src_w),
    .src_h   (src_h),
    .raw     (raw),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  bds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  bds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .avg        (avg)
  );

endmodule

[sv/bds_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bds_front.sv]
// Front end: takes raw pixels, tracks column and row, forms pair sums.
// Depends on bds_pkg and bds_if; pushes line-store operations to bds_queue.
module bds_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bds_pkg::SIZE_W-1:0]  src_w,
  input  logic [bds_pkg::SIZE_W-1:0]  src_h,
  bds_in_if.sink                      raw,
  input  logic                        q_full,
  output logic                        push,
  output bds_pkg::op_t                push_op
);

  logic [bds_pkg::COL_W-1:0]  col, col_next;
  logic [bds_pkg::ROW_W-1:0]  row, row_next;
  logic [bds_pkg::PIX_W-1:0]  pend;
  logic [bds_pkg::SIZE_W-1:0] w, h, w_even, h_even, x_inc, y_inc, x_ext, y_ext;
  logic                       accept, in_block;

  always_comb begin
    w = src_w;
    if (src_w < bds_pkg::MIN_SIZE) begin
      w = bds_pkg::MIN_SIZE;
    end else if (src_w > bds_pkg::SIZE_W'(bds_pkg::MAX_WIDTH)) begin
      w = bds_pkg::SIZE_W'(bds_pkg::MAX_WIDTH);
    end
    h = src_h;
    if (src_h < bds_pkg::MIN_SIZE) begin
      h = bds_pkg::MIN_SIZE;
    end else if (src_h > bds_pkg::SIZE_W'(bds_pkg::MAX_HEIGHT)) begin
      h = bds_pkg::SIZE_W'(bds_pkg::MAX_HEIGHT);
    end
    w_even = {w[bds_pkg::SIZE_W-1:1], 1'b0};
    h_even = {h[bds_pkg::SIZE_W-1:1], 1'b0};
  end

  assign x_ext    = bds_pkg::SIZE_W'(col);
  assign y_ext    = bds_pkg::SIZE_W'(row);
  assign raw.ready = !q_full;
  assign accept   = raw.valid && raw.ready;
  assign in_block = (x_ext < w_even) && (y_ext < h_even);

  assign push         = accept && in_block && col[0];
  assign push_op.read = row[0];
  assign push_op.slot = col[bds_pkg::COL_W-1:1];
  assign push_op.pair = bds_pkg::PAIR_W'(pend) + bds_pkg::PAIR_W'(raw.pixel_in);
  assign push_op.last = (x_ext == w_even - bds_pkg::SIZE_W'(1))
                     && (y_ext == h_even - bds_pkg::SIZE_W'(1));

  // advance raster position, wrap at line and frame end
  always_comb begin
    x_inc    = x_ext + bds_pkg::SIZE_W'(1);
    y_inc    = y_ext + bds_pkg::SIZE_W'(1);
    col_next = x_inc[bds_pkg::COL_W-1:0];
    row_next = row;
    if (x_inc >= w) begin
      col_next = '0;
      row_next = y_inc[bds_pkg::ROW_W-1:0];
      if (y_inc >= h) begin
        row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_block && !col[0]) begin
      pend <= raw.pixel_in;
    end
  end

endmodule

[sv/bds_queue.sv]
// Short FIFO of line-store operations between front and back end.
// Depends on bds_pkg.
module bds_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bds_pkg::op_t push_op,
  output logic         full,
  output logic         head_valid,
  output bds_pkg::op_t head_op,
  input  logic         pop
);

  bds_pkg::op_t               mem [bds_pkg::QDEPTH];
  logic [bds_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [bds_pkg::QCNT_W-1:0] count;

  assign full       = (count == bds_pkg::QCNT_W'(bds_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bds_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bds_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bds_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bds_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

endmodule

[sv/bds_back.sv]
// Back end: applies queued operations to the pair line store and
// averages odd-row pairs into the output register.
// Depends on bds_pkg, bds_if and bds_ram.
module bds_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  bds_pkg::op_t head_op,
  output logic         pop,
  bds_out_if.source    avg
);

  logic                       ram_wr, ram_rd;
  logic [bds_pkg::PAIR_W-1:0] rd_data;
  logic                       s1_valid, s1_last, s1_ready;
  logic [bds_pkg::PAIR_W-1:0] s1_pair;
  logic                       out_valid, out_free;
  logic [bds_pkg::SUM_W-1:0]  sum;

  assign out_free = !out_valid || avg.ready;
  assign s1_ready = !s1_valid || out_free;
  assign pop      = head_valid && (!head_op.read || s1_ready);
  assign ram_wr   = pop && !head_op.read;
  assign ram_rd   = pop && head_op.read;

  bds_ram #(
    .WIDTH (bds_pkg::PAIR_W),
    .DEPTH (bds_pkg::LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (head_op.slot),
    .wr_data (head_op.pair),
    .rd_en   (ram_rd),
    .rd_addr (head_op.slot),
    .rd_data (rd_data)
  );

  assign sum = bds_pkg::SUM_W'(rd_data) + bds_pkg::SUM_W'(s1_pair);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= ram_rd;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd) begin
      s1_pair <= head_op.pair;
      s1_last <= head_op.last;
    end
    if (out_free && s1_valid) begin
      avg.pixel_out  <= sum[bds_pkg::SUM_W-1:2];
      avg.frame_last <= s1_last;
    end
  end

  assign avg.valid = out_valid;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    ram_rd |=> s1_valid)
    else $error("line read lost");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_pair) && $stable(s1_last))
    else $error("stalled stage changed");

endmodule

[sim/tb_box_downsample_2x2_unit.sv]
`timescale 1ns / 1ps
// Testbench for box_downsample_2x2_unit: streams raw frames, writes sizes over APB,
// predicts each 2x2 average and frame_last, and checks every output request in order.
// Depends on bds_pkg, bds_if and the RTL of the downsampler.
module tb_box_downsample_2x2_unit;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    logic [bds_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } avg_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bds_pkg::ADDR_W-1:0] paddr;
  logic [bds_pkg::DATA_W-1:0] pwdata;
  logic [bds_pkg::DATA_W-1:0] prdata;
  logic pready;

  bds_in_if  raw_ch ();
  bds_out_if avg_ch ();

  box_downsample_2x2_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .raw     (raw_ch),
    .avg     (avg_ch)
  );

  logic [bds_pkg::SIZE_W-1:0] width_reg;
  logic [bds_pkg::SIZE_W-1:0] height_reg;
  logic [bds_pkg::PAIR_W-1:0] pair_store [bds_pkg::LINE_DEPTH];
  logic [bds_pkg::PAIR_W-1:0] left_pixel;
  int unsigned col;
  int unsigned row;

  avg_result_t expected_avg [$];
  int errors = 0;
  int pixels_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_box_downsample_2x2_unit: done, errors");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [bds_pkg::SIZE_W-1:0] v,
                                            input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void downsample_pixel(input logic [bds_pkg::PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned w_even;
    int unsigned h_even;
    int unsigned slot;
    logic [bds_pkg::PAIR_W-1:0] pair;
    logic [bds_pkg::SUM_W-1:0] sum;
    avg_result_t r;
    w = clamp_dim(width_reg, bds_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, bds_pkg::MAX_HEIGHT);
    w_even = w & ~32'd1;
    h_even = h & ~32'd1;
    if (col < w_even && row < h_even) begin
      if (col % 2 == 0) begin
        left_pixel = bds_pkg::PAIR_W'(px);
      end else begin
        pair = left_pixel + bds_pkg::PAIR_W'(px);
        slot = (col / 2) % bds_pkg::LINE_DEPTH;
        if (row % 2 == 0) begin
          pair_store[slot] = pair;
        end else begin
          sum = bds_pkg::SUM_W'(pair_store[slot]) + bds_pkg::SUM_W'(pair);
          r.pixel = sum[bds_pkg::SUM_W-1:2];
          r.last = (col == w_even - 1) && (row == h_even - 1);
          expected_avg.push_back(r);
        end
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function automatic logic [bds_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bds_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_avg(input logic [bds_pkg::PIX_W-1:0] pix, input logic last);
    avg_result_t e;
    if (expected_avg.size() == 0) begin
      report_mismatch($sformatf("output request with none expected: pixel_out=%0d last=%0b",
                                pix, last));
      return;
    end
    e = expected_avg.pop_front();
    if (pix !== e.pixel)
      report_mismatch($sformatf("pixel_out=%0d, expected %0d", pix, e.pixel));
    if (last !== e.last)
      report_mismatch($sformatf("frame_last=%0b, expected %0b", last, e.last));
  endtask

  initial begin
    avg_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && avg_ch.valid && avg_ch.ready) check_avg(avg_ch.pixel_out, avg_ch.frame_last);
      if (hold_left > 0) begin
        hold_left--;
        avg_ch.ready <= 1'b0;
      end else begin
        avg_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [bds_pkg::SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bds_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= bds_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bds_pkg::REG_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic send_pixel(input logic [bds_pkg::PIX_W-1:0] px);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      raw_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_ch.valid    <= 1'b1;
    raw_ch.pixel_in <= px;
    do @(posedge clk); while (!raw_ch.ready);
    downsample_pixel(px);
    pixels_sent++;
  endtask

  task automatic settle();
    raw_ch.valid <= 1'b0;
    while (expected_avg.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [bds_pkg::SIZE_W-1:0] w,
                          input logic [bds_pkg::SIZE_W-1:0] h);
    settle();
    write_reg(bds_pkg::REG_WIDTH, w);
    write_reg(bds_pkg::REG_HEIGHT, h);
  endtask

  task automatic finish_frame();
    while (col != 0 || row != 0) send_pixel(rand_pixel());
  endtask

  task automatic send_frame();
    send_pixel(rand_pixel());
    finish_frame();
  endtask

  task automatic send_block(input logic [bds_pkg::PIX_W-1:0] a, input logic [bds_pkg::PIX_W-1:0] b,
                            input logic [bds_pkg::PIX_W-1:0] c, input logic [bds_pkg::PIX_W-1:0] d);
    send_pixel(a);
    send_pixel(b);
    send_pixel(c);
    send_pixel(d);
  endtask

  // start inside a frame at the reset size, then shrink below the current column
  task automatic test_default_size_midframe();
    send_block(8'd10, 8'd20, 8'd30, 8'd40);
    send_pixel(8'd50);
    settle();
    write_reg(bds_pkg::REG_WIDTH, 11'd4);
    write_reg(bds_pkg::REG_HEIGHT, 11'd2);
    send_pixel(8'd60);
    send_block(8'd1, 8'd2, 8'd3, 8'd4);
    finish_frame();
  endtask

  task automatic test_small_frames();
    set_size(11'd2, 11'd2);
    send_block(8'd255, 8'd255, 8'd255, 8'd255);
    send_block(8'd0, 8'd0, 8'd0, 8'd0);
    send_block(8'd3, 8'd3, 8'd3, 8'd2);
    set_size(11'd0, 11'd1);
    send_block(8'd255, 8'd0, 8'd0, 8'd255);
    set_size(11'd1, 11'd0);
    send_block(8'd128, 8'd127, 8'd1, 8'd254);
    set_size(11'd3, 11'd3);
    send_frame();
  endtask

  // shrink the height once the row counter is already past it
  task automatic test_height_midframe();
    set_size(11'd4, 11'd8);
    repeat (22) send_pixel(rand_pixel());
    settle();
    write_reg(bds_pkg::REG_HEIGHT, 11'd4);
    finish_frame();
    send_frame();
  endtask

  task automatic test_random_frames();
    int phase_start;
    logic [bds_pkg::SIZE_W-1:0] w;
    logic [bds_pkg::SIZE_W-1:0] h;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 2) != 0) begin
          w = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(17, 80))
                                          : 11'($urandom_range(2, 16));
          h = 11'($urandom_range(2, 9));
          if ($urandom_range(0, 19) == 0) w = 11'($urandom_range(0, 1));
          if ($urandom_range(0, 19) == 0) h = 11'($urandom_range(0, 1));
          set_size(w, h);
        end
        send_frame();
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_size(11'd4, 11'd20);
    hold_left = 300;
    send_frame();
    recv_stall_pct = 23;
    hold_left = 150;
    send_frame();
  endtask

  // oversized width and height, then shrink mid-frame to end the frame early
  task automatic test_size_limits();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    set_size(11'd2047, 11'd2);
    repeat (6) send_pixel(rand_pixel());
    settle();
    write_reg(bds_pkg::REG_WIDTH, 11'd4);
    finish_frame();
    set_size(11'd2, 11'd2047);
    repeat (8) send_pixel(rand_pixel());
    settle();
    write_reg(bds_pkg::REG_HEIGHT, 11'd2);
    finish_frame();
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    raw_ch.valid    <= 1'b0;
    raw_ch.pixel_in <= '0;
    width_reg  = bds_pkg::RESET_WIDTH;
    height_reg = bds_pkg::RESET_HEIGHT;
    left_pixel = '0;
    col = 0;
    row = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_size_midframe();
    test_small_frames();
    test_height_midframe();
    test_random_frames();
    test_output_backpressure();
    test_size_limits();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_box_downsample_2x2_unit: done, clean");
    end else begin
      $display("tb_box_downsample_2x2_unit: done, errors");
    end
    $finish;
  end

endmodule
